// ===== design/rational_arith_unit_core_defines.svh =====
// Assertion macros shared by the rational arithmetic unit files.
`ifndef RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH

// Check that a condition implies a consequence at the same edge.
`define RAU_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence at the next edge.
`define RAU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rau_pkg.sv =====
// Package: types and codes of the rational arithmetic unit.
package rau_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    localparam int unsigned NUM_W = 32;
    localparam int unsigned DEN_W = 31;
    localparam int unsigned RES_NUM_W = 64;
    localparam int unsigned RES_DEN_W = 62;
    localparam int unsigned WORD_W = 64;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef struct packed {
        t_op                  req_type;
        logic signed [31:0]   a_numerator;
        logic        [30:0]   a_denominator;
        logic signed [31:0]   b_numerator;
        logic        [30:0]   b_denominator;
    } t_req;

    typedef struct packed {
        logic signed [63:0]   res_numerator;
        logic        [61:0]   res_denominator;
        logic                 status;
    } t_res;
endpackage

// ===== design/rau_if.sv =====
// Valid/ready channel interface carrying one payload item.
interface rau_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rational_arith_unit_core.sv =====
// Top level: rational arithmetic unit with iterative gcd reduction.
//
// Usage: one request item on i_req (operation code and two fractions) gives
// one result item on o_res (reduced numerator, positive denominator, status).
// A zero result is 0/1; a divide by a zero fraction or a zero denominator
// gives 0/1 with status set.
// The block works on one item at a time and drops i_req.ready while busy.
// A 64-bit shift-and-add unit forms the cross products one bit per cycle
// (two products for multiply and divide, three for add and subtract). A
// 64-bit restoring divider then runs one Euclid remainder per step, each
// followed by a check, and two exact divisions by the gcd. A zero result
// ends at the check, before the divisions by the gcd; an error result is
// valid the cycle after acceptance.
// The result register holds the item until the receiver takes it; the next
// request is taken only after the result has been handed over, so a stalled
// receiver simply holds the block.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// the result valid; no clearing pass is needed.
module rational_arith_unit_core (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_if.sink   i_req,
    rau_if.source o_res
);
    import rau_pkg::*;
    `include "rational_arith_unit_core_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_COMB, S_EUC_CHK, S_EUC_DIV, S_RED_N, S_RED_D, S_OUT
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic [1:0]  r_mul_idx;       // which product is in progress
    logic [6:0]  r_cnt;
    logic [63:0] r_p0, r_p1, r_p2; // products
    logic [63:0] r_mc, r_mp;       // multiplicand, multiplier
    logic [63:0] r_acc;
    logic        r_s0, r_s1;       // signs of an, bn
    logic [31:0] r_am, r_bm;       // magnitudes
    logic [30:0] r_ad, r_bd;
    logic        r_neg;
    logic [63:0] r_mag, r_den, r_x, r_y;
    logic [63:0] r_q, r_rem, r_dvd, r_dvs;
    t_res        r_out;
    logic        r_out_v;

    // shared 65-bit subtract for division steps
    logic [64:0] w_trial;
    logic [63:0] w_shrem;
    assign w_shrem = {r_rem[62:0], r_dvd[63]};
    assign w_trial = {r_rem[63], w_shrem} - {1'b0, r_dvs};

    // signed combination of products for add/sub
    logic signed [64:0] w_sum;
    logic signed [64:0] w_t1, w_t2;
    always_comb begin
        w_t1 = r_s0 ? -$signed({1'b0, r_p0}) : $signed({1'b0, r_p0});
        w_t2 = r_s1 ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
        w_sum = (r_op == OP_SUB) ? (w_t1 - w_t2) : (w_t1 + w_t2);
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_out_v;
    assign o_res.valid = r_out_v;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op <= i_req.payload.req_type;
                        r_s0 <= i_req.payload.a_numerator[31];
                        r_s1 <= i_req.payload.b_numerator[31];
                        r_am <= i_req.payload.a_numerator[31]
                            ? 32'(-i_req.payload.a_numerator) : i_req.payload.a_numerator;
                        r_bm <= i_req.payload.b_numerator[31]
                            ? 32'(-i_req.payload.b_numerator) : i_req.payload.b_numerator;
                        r_ad <= i_req.payload.a_denominator;
                        r_bd <= i_req.payload.b_denominator;
                        if (i_req.payload.a_denominator == '0
                            || i_req.payload.b_denominator == '0
                            || (i_req.payload.req_type == OP_DIV
                                && i_req.payload.b_numerator == '0)) begin
                            r_out <= '{res_numerator: '0, res_denominator: 62'd1,
                                       status: STATUS_DIV_ZERO};
                            r_out_v <= 1'b1;
                        end else begin
                            r_mul_idx <= 2'd0;
                            r_state <= S_MUL;
                            r_cnt <= '0;
                            r_acc <= '0;
                            // first product: numerator-side term
                            r_mc <= {32'd0, (i_req.payload.a_numerator[31]
                                ? 32'(-i_req.payload.a_numerator)
                                : i_req.payload.a_numerator)};
                            r_mp <= (i_req.payload.req_type == OP_MUL)
                                ? {32'd0, (i_req.payload.b_numerator[31]
                                    ? 32'(-i_req.payload.b_numerator)
                                    : i_req.payload.b_numerator)}
                                : {33'd0, i_req.payload.b_denominator};
                        end
                    end
                end
                S_MUL: begin
                    // shift-and-add: one multiplier bit per cycle
                    r_acc <= r_mp[0] ? r_acc + r_mc : r_acc;
                    r_mc <= {r_mc[62:0], 1'b0};
                    r_mp <= {1'b0, r_mp[63:1]};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd31) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        unique case (r_mul_idx)
                            2'd0: begin
                                r_p0 <= r_mp[0] ? r_acc + r_mc : r_acc;
                                r_mul_idx <= 2'd1;
                                // second: bn*ad, or the denominator product for mul and div
                                if (r_op == OP_MUL) begin
                                    r_mul_idx <= 2'd2;
                                    r_mc <= {33'd0, r_ad};
                                    r_mp <= {33'd0, r_bd};
                                end else if (r_op == OP_DIV) begin
                                    r_mul_idx <= 2'd2;
                                    r_mc <= {33'd0, r_ad};
                                    r_mp <= {32'd0, r_bm};
                                end else begin
                                    r_mc <= {32'd0, r_bm};
                                    r_mp <= {33'd0, r_ad};
                                end
                            end
                            2'd1: begin
                                r_p1 <= r_mp[0] ? r_acc + r_mc : r_acc;
                                r_mul_idx <= 2'd2;
                                r_mc <= {33'd0, r_ad};
                                r_mp <= {33'd0, r_bd};
                            end
                            default: begin
                                r_p2 <= r_mp[0] ? r_acc + r_mc : r_acc;
                                r_state <= S_COMB;
                            end
                        endcase
                    end
                end
                S_COMB: begin
                    r_den <= r_p2;
                    if (r_op == OP_ADD || r_op == OP_SUB) begin
                        r_neg <= w_sum[64];
                        r_mag <= w_sum[64] ? 64'(-w_sum) : w_sum[63:0];
                        r_x <= w_sum[64] ? 64'(-w_sum) : w_sum[63:0];
                    end else begin
                        r_neg <= r_s0 ^ r_s1;
                        r_mag <= r_p0;
                        r_x <= r_p0;
                    end
                    r_y <= r_p2;
                    r_state <= S_EUC_CHK;
                end
                S_EUC_CHK: begin
                    if (r_mag == '0) begin
                        r_out <= '{res_numerator: '0, res_denominator: 62'd1,
                                   status: STATUS_OK};
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_y == '0) begin
                        // r_x is the gcd: divide numerator by it
                        r_dvs <= r_x;
                        r_dvd <= r_mag;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_RED_N;
                    end else begin
                        r_dvs <= r_y;
                        r_dvd <= r_x;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= S_EUC_DIV;
                    end
                end
                default: begin
                    // S_EUC_DIV, S_RED_N, S_RED_D: restoring division step
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_rem <= w_trial[64] ? w_shrem : w_trial[63:0];
                    r_q <= {r_q[62:0], ~w_trial[64]};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) begin
                        if (r_state == S_EUC_DIV) begin
                            r_x <= r_y;
                            r_y <= w_trial[64] ? w_shrem : w_trial[63:0];
                            r_state <= S_EUC_CHK;
                        end else if (r_state == S_RED_N) begin
                            r_mag <= {r_q[62:0], ~w_trial[64]};
                            r_dvd <= r_den;
                            r_rem <= '0;
                            r_cnt <= '0;
                            r_state <= S_RED_D;
                        end else begin
                            r_out <= '{res_numerator: r_neg ? 64'(-r_mag) : r_mag,
                                       res_denominator: {r_q[60:0], ~w_trial[64]},
                                       status: STATUS_OK};
                            r_out_v <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    `RAU_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, i_req.ready,
        r_state == S_IDLE && !o_res.valid, "ready outside idle")
    `RAU_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, o_res.valid,
        o_res.payload.res_denominator != '0, "zero result denominator")
    `RAU_ASSERT_IMPL(a_err_shape, i_clk, i_rst_n,
        o_res.valid && o_res.payload.status == STATUS_DIV_ZERO,
        o_res.payload.res_numerator == '0, "error result not zero")
    `RAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready,
        o_res.valid && $stable(o_res.payload), "result dropped while stalled")
endmodule
